FILE: rtl/fpd_pkg.sv
// ----------------------------------------------------------------------------
// fpd_pkg: shared definitions of the fuzzy PD controller
// Fixed set bounds, rule table, widths, tag codes and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package fpd_pkg;

    localparam int IN_W            = 16;
    localparam int DRIVE_W         = 8;
    localparam int NUM_SETS        = 7;
    localparam int SET_W           = $clog2(NUM_SETS);
    localparam int OUTPUT_SPAN_DEF = 200;
    localparam int PEAK            = 100;
    localparam int MU_W            = 7;
    localparam int LANE_LAT        = 4;

    // Reciprocal scaling used by the membership lanes.
    localparam int RCP_SHIFT = 24;
    localparam int RCP_W     = 17;
    localparam int Q_W       = 10;

    localparam int SET_LO [NUM_SETS] = '{-100, -75, -50, -20,   0, 30,  55};
    localparam int SET_HI [NUM_SETS] = '{ -55, -30,   0,  20,  50, 75, 100};

    // (m-a)*(b-m) of each set, m being the midpoint truncated toward zero.
    localparam int SET_Q [NUM_SETS] = '{506, 506, 625, 400, 625, 506, 506};
    localparam int SET_RCP [NUM_SETS] = '{
        (1 << 24) / 506, (1 << 24) / 506, (1 << 24) / 625, (1 << 24) / 400,
        (1 << 24) / 625, (1 << 24) / 506, (1 << 24) / 506
    };

    // Output set per rule: row is the error set, column the error-change set.
    localparam logic [SET_W-1:0] RULE_TAB [NUM_SETS][NUM_SETS] = '{
        '{3'd6, 3'd6, 3'd6, 3'd6, 3'd5, 3'd4, 3'd3},
        '{3'd6, 3'd6, 3'd5, 3'd5, 3'd4, 3'd3, 3'd2},
        '{3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd2, 3'd1},
        '{3'd5, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1},
        '{3'd5, 3'd4, 3'd3, 3'd2, 3'd2, 3'd1, 3'd0},
        '{3'd4, 3'd3, 3'd2, 3'd1, 3'd1, 3'd0, 3'd0},
        '{3'd3, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0}
    };

    // What travels through the membership lanes.
    localparam logic [1:0] TAG_E   = 2'd0;
    localparam logic [1:0] TAG_DE  = 2'd1;
    localparam logic [1:0] TAG_BIN = 2'd2;

    typedef struct packed {
        logic             load;
        logic             issue_e;
        logic             issue_de;
        logic             row_en;
        logic [SET_W-1:0] row;
        logic             issue_bin;
        logic             div_start;
        logic             res_load;
    } t_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic div_done;
    } t_status;

endpackage

FILE: rtl/fpd_if.sv
// ----------------------------------------------------------------------------
// fpd_in_if / fpd_out_if: valid-ready channels of the fuzzy PD controller
// One carries the reference and position item, the other the drive result.
// ----------------------------------------------------------------------------
interface fpd_in_if;
    import fpd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] reference;
    logic signed [IN_W-1:0] position;

    modport source (output valid, output reference, output position, input ready);
    modport sink (input valid, input reference, input position, output ready);
endinterface

interface fpd_out_if;
    import fpd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;
    logic                      no_rule_fired;

    modport source (output valid, output drive, output no_rule_fired, input ready);
    modport sink (input valid, input drive, input no_rule_fired, output ready);
endinterface

FILE: rtl/fuzzy_pd_controller.sv
// ----------------------------------------------------------------------------
// fuzzy_pd_controller: Mamdani fuzzy PD controller, top level
//
// Each input item carries a reference and a measured position. The block
// forms the 16-bit wrapped error and the error change against the error of
// the previous item, fuzzifies both with seven parabolic sets, evaluates the
// 7x7 rule table with min strength, max-aggregates the clipped output sets
// over the output bins and returns the centroid, truncated toward zero, as
// one result item. When no rule fires the drive is 0 and no_rule_fired is 1.
//
// The block works on one item at a time: i_in.ready is high only while idle.
// An item's time from acceptance to the result being written is set mostly by
// the bin sweep (one output bin per cycle through the membership lanes), and
// the rest by the one-bit-per-cycle centroid divider.
// The result waits in an output register; a stalled receiver holds it there
// while the next item is already accepted and worked on, and that item's
// result is only written once the register has been taken.
// Reset clears the stored last error to zero and empties all control state.
// ----------------------------------------------------------------------------
module fuzzy_pd_controller #(
    parameter int OUTPUT_SPAN = fpd_pkg::OUTPUT_SPAN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpd_in_if.sink    i_in,
    fpd_out_if.source o_out
);
    import fpd_pkg::*;

    localparam int BIN_CW = $clog2(OUTPUT_SPAN);

    t_cmd              w_cmd;
    t_status           w_sts;
    logic [BIN_CW-1:0] w_bin;

    // The sequencer owns the handshakes and steps the datapath.
    fpd_ctrl #(.OUTPUT_SPAN(OUTPUT_SPAN)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_bin       (w_bin)
    );

    // The datapath holds every value of the item and the result register.
    fpd_dp #(.OUTPUT_SPAN(OUTPUT_SPAN)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_bin           (w_bin),
        .o_sts           (w_sts),
        .i_reference     (i_in.reference),
        .i_position      (i_in.position),
        .o_drive         (o_out.drive),
        .o_no_rule_fired (o_out.no_rule_fired)
    );

    // Only one item is in flight: acceptance drops ready at once.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted twice in a row");

    // A result without any fired rule must carry a zero drive.
    a_nrf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.no_rule_fired) |-> (o_out.drive == '0))
        else $error("drive nonzero although no rule fired");

    // The centroid stays within the span of the output sets.
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.drive >= -8'sd100) && (o_out.drive <= 8'sd100)))
        else $error("drive out of range");
endmodule

FILE: rtl/fpd_lane.sv
// ----------------------------------------------------------------------------
// fpd_lane: membership height of one fuzzy set
// Four-stage pipeline giving floor(100*(x-a)*(b-x)/q) inside the set, else 0.
// ----------------------------------------------------------------------------
module fpd_lane #(
    parameter int SET_IDX = 0
) (
    input  logic                           i_clk,
    input  logic signed [fpd_pkg::IN_W-1:0] i_x,
    output logic [fpd_pkg::MU_W-1:0]       o_h
);
    import fpd_pkg::*;

    localparam int U_W = 7;
    localparam int N_W = 17;
    localparam int H_W = 8;
    localparam int P_W = N_W + RCP_W;
    localparam int C_W = H_W + Q_W + 1;
    localparam logic signed [IN_W-1:0] LO = IN_W'(SET_LO[SET_IDX]);
    localparam logic signed [IN_W-1:0] HI = IN_W'(SET_HI[SET_IDX]);

    logic signed [IN_W:0] w_u;
    logic signed [IN_W:0] w_v;
    logic [2*U_W-1:0]     w_p;
    logic [P_W-1:0]       w_prod;
    logic [C_W-1:0]       w_chk;

    logic           r_in;
    logic [U_W-1:0] r_u;
    logic [U_W-1:0] r_v;
    logic [N_W-1:0] r_n;
    logic [N_W-1:0] r_n3;
    logic [H_W-1:0] r_h0;
    logic [H_W-1:0] r_h;

    assign w_u    = (IN_W+1)'(i_x) - (IN_W+1)'(LO);
    assign w_v    = (IN_W+1)'(HI) - (IN_W+1)'(i_x);
    assign w_p    = r_u * r_v;
    assign w_prod = P_W'(r_n) * P_W'(SET_RCP[SET_IDX]);
    assign w_chk  = (C_W'(r_h0) + C_W'(1)) * C_W'(SET_Q[SET_IDX]);

    always_ff @(posedge i_clk) begin
        r_in <= (i_x > LO) && (i_x < HI);
        r_u  <= w_u[U_W-1:0];
        r_v  <= w_v[U_W-1:0];
        r_n  <= r_in ? N_W'(w_p) * N_W'(PEAK) : '0;
        r_h0 <= w_prod[RCP_SHIFT +: H_W];
        r_n3 <= r_n;
        // The reciprocal may fall short by one; a single compare corrects it.
        r_h  <= (w_chk <= C_W'(r_n3)) ? r_h0 + H_W'(1) : r_h0;
    end

    assign o_h = r_h[MU_W-1:0];
endmodule

FILE: rtl/fpd_div.sv
// ----------------------------------------------------------------------------
// fpd_div: restoring unsigned divider
// One quotient bit per cycle; o_done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module fpd_div #(
    parameter int MAG_W = 21,
    parameter int DEN_W = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [MAG_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [DEN_W:0]   w_shift;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [MAG_W-1:0] r_quo;

    assign w_shift = {r_rem, r_quo[MAG_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MAG_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
            r_quo <= {r_quo[MAG_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

FILE: rtl/fpd_ctrl.sv
// ----------------------------------------------------------------------------
// fpd_ctrl: sequencer of the fuzzy PD controller
// Walks one item through fuzzification, rule evaluation, bin aggregation,
// division and result hand-over.
// ----------------------------------------------------------------------------
module fpd_ctrl #(
    parameter int OUTPUT_SPAN = fpd_pkg::OUTPUT_SPAN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  fpd_pkg::t_status               i_sts,
    output fpd_pkg::t_cmd                  o_cmd,
    output logic [$clog2(OUTPUT_SPAN)-1:0] o_bin
);
    import fpd_pkg::*;

    localparam int BIN_CW = $clog2(OUTPUT_SPAN);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MU_E     = 4'd1;
    localparam logic [3:0] ST_MU_DE    = 4'd2;
    localparam logic [3:0] ST_MU_WAIT  = 4'd3;
    localparam logic [3:0] ST_RULE     = 4'd4;
    localparam logic [3:0] ST_BIN      = 4'd5;
    localparam logic [3:0] ST_BIN_WAIT = 4'd6;
    localparam logic [3:0] ST_DIV      = 4'd7;
    localparam logic [3:0] ST_RES      = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [SET_W-1:0]  r_row, n_row;
    logic [BIN_CW-1:0] r_bin, n_bin;
    logic              r_out_v, n_out_v;
    t_cmd              w_cmd;

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_bin   = r_bin;
        n_out_v = r_out_v && !i_out_ready;
        w_cmd   = '0;
        w_cmd.row = r_row;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = ST_MU_E;
                end
            end
            ST_MU_E: begin
                w_cmd.issue_e = 1'b1;
                n_state       = ST_MU_DE;
            end
            ST_MU_DE: begin
                w_cmd.issue_de = 1'b1;
                n_state        = ST_MU_WAIT;
            end
            ST_MU_WAIT: begin
                if (!i_sts.pipe_busy) begin
                    n_row   = '0;
                    n_state = ST_RULE;
                end
            end
            ST_RULE: begin
                w_cmd.row_en = 1'b1;
                n_row        = r_row + SET_W'(1);
                if (r_row == SET_W'(NUM_SETS - 1)) begin
                    n_bin   = '0;
                    n_state = ST_BIN;
                end
            end
            ST_BIN: begin
                w_cmd.issue_bin = 1'b1;
                n_bin           = r_bin + BIN_CW'(1);
                if (r_bin == BIN_CW'(OUTPUT_SPAN - 1)) begin
                    n_state = ST_BIN_WAIT;
                end
            end
            ST_BIN_WAIT: begin
                if (!i_sts.pipe_busy) begin
                    w_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_RES;
                end
            end
            ST_RES: begin
                if (!r_out_v || i_out_ready) begin
                    w_cmd.res_load = 1'b1;
                    n_out_v        = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_bin   <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_bin   <= n_bin;
            r_out_v <= n_out_v;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_v;
    assign o_cmd       = w_cmd;
    assign o_bin       = r_bin;
endmodule

FILE: rtl/fpd_dp.sv
// ----------------------------------------------------------------------------
// fpd_dp: datapath of the fuzzy PD controller
// Error registers, membership lanes, rule strengths, aggregation and
// centroid accumulation, divider and the result register.
// ----------------------------------------------------------------------------
module fpd_dp #(
    parameter int OUTPUT_SPAN = fpd_pkg::OUTPUT_SPAN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fpd_pkg::t_cmd                       i_cmd,
    input  logic [$clog2(OUTPUT_SPAN)-1:0]      i_bin,
    output fpd_pkg::t_status                    o_sts,
    input  logic signed [fpd_pkg::IN_W-1:0]     i_reference,
    input  logic signed [fpd_pkg::IN_W-1:0]     i_position,
    output logic signed [fpd_pkg::DRIVE_W-1:0]  o_drive,
    output logic                                o_no_rule_fired
);
    import fpd_pkg::*;

    localparam int BIN_CW = $clog2(OUTPUT_SPAN);
    localparam int XB_W   = BIN_CW + 1;
    localparam int NUM_W  = $clog2(PEAK * OUTPUT_SPAN * OUTPUT_SPAN / 2 + 1) + 1;
    localparam int MAG_W  = NUM_W - 1;
    localparam int DEN_W  = $clog2(PEAK * OUTPUT_SPAN + 1);
    localparam int AX_W   = MU_W + XB_W + 1;

    logic signed [IN_W-1:0]  r_e;
    logic signed [IN_W-1:0]  r_de;
    logic signed [IN_W-1:0]  r_last;
    logic signed [IN_W-1:0]  w_e;
    logic signed [XB_W-1:0]  w_bx;
    logic signed [IN_W-1:0]  w_x;
    logic [MU_W-1:0]         w_h [NUM_SETS];

    logic                    r_tv [LANE_LAT];
    logic [1:0]              r_tg [LANE_LAT];
    logic signed [XB_W-1:0]  r_tx [LANE_LAT];

    logic [MU_W-1:0]         r_mu_e  [NUM_SETS];
    logic [MU_W-1:0]         r_mu_de [NUM_SETS];
    logic [MU_W-1:0]         r_w     [NUM_SETS];
    logic [MU_W-1:0]         n_w     [NUM_SETS];

    logic                    r_agg_v;
    logic [MU_W-1:0]         r_agg;
    logic signed [XB_W-1:0]  r_agg_x;
    logic [MU_W-1:0]         w_agg;
    logic signed [AX_W-1:0]  w_ax;
    logic signed [NUM_W-1:0] r_num;
    logic [DEN_W-1:0]        r_den;

    logic                    r_neg;
    logic [NUM_W-1:0]        w_mag;
    logic                    w_div_done;
    logic [MAG_W-1:0]        w_quo;
    logic [DRIVE_W-1:0]      w_q8;
    logic                    w_fired;
    logic                    w_busy;

    logic signed [DRIVE_W-1:0] r_drive;
    logic                      r_nrf;

    assign w_e  = i_reference - i_position;
    assign w_bx = $signed({1'b0, i_bin}) - XB_W'(OUTPUT_SPAN / 2);
    assign w_x  = i_cmd.issue_e ? r_e : (i_cmd.issue_de ? r_de : IN_W'(w_bx));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (i_cmd.load) begin
            r_e    <= w_e;
            r_de   <= w_e - r_last;
            r_last <= w_e;
        end
    end

    for (genvar g = 0; g < NUM_SETS; g++) begin : g_lane
        fpd_lane #(.SET_IDX(g)) u_lane (
            .i_clk (i_clk),
            .i_x   (w_x),
            .o_h   (w_h[g])
        );
    end

    // Tags run alongside the lanes so that each result finds its use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANE_LAT; k++) begin
                r_tv[k] <= 1'b0;
            end
            r_agg_v <= 1'b0;
        end else begin
            r_tv[0] <= i_cmd.issue_e || i_cmd.issue_de || i_cmd.issue_bin;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_tv[k] <= r_tv[k-1];
            end
            r_agg_v <= r_tv[LANE_LAT-1] && (r_tg[LANE_LAT-1] == TAG_BIN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_tg[0] <= i_cmd.issue_e ? TAG_E : (i_cmd.issue_de ? TAG_DE : TAG_BIN);
        r_tx[0] <= w_bx;
        for (int k = 1; k < LANE_LAT; k++) begin
            r_tg[k] <= r_tg[k-1];
            r_tx[k] <= r_tx[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_tv[LANE_LAT-1] && (r_tg[LANE_LAT-1] == TAG_E)) begin
            for (int s = 0; s < NUM_SETS; s++) begin
                r_mu_e[s] <= w_h[s];
            end
        end
        if (r_tv[LANE_LAT-1] && (r_tg[LANE_LAT-1] == TAG_DE)) begin
            for (int s = 0; s < NUM_SETS; s++) begin
                r_mu_de[s] <= w_h[s];
            end
        end
    end

    // One rule row per cycle: strongest firing per output set.
    always_comb begin
        logic [MU_W-1:0] mu_row;
        logic [MU_W-1:0] m;
        logic [MU_W-1:0] cand;
        mu_row = r_mu_e[i_cmd.row];
        for (int o = 0; o < NUM_SETS; o++) begin
            cand = '0;
            for (int j = 0; j < NUM_SETS; j++) begin
                m = (mu_row < r_mu_de[j]) ? mu_row : r_mu_de[j];
                if ((RULE_TAB[i_cmd.row][j] == SET_W'(o)) && (m > cand)) begin
                    cand = m;
                end
            end
            n_w[o] = (cand > r_w[o]) ? cand : r_w[o];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int o = 0; o < NUM_SETS; o++) begin
                r_w[o] <= '0;
            end
        end else if (i_cmd.row_en) begin
            r_w <= n_w;
        end
    end

    // Clip each output set at its strength and keep the highest.
    always_comb begin
        logic [MU_W-1:0] c;
        w_agg = '0;
        for (int o = 0; o < NUM_SETS; o++) begin
            c = (w_h[o] < r_w[o]) ? w_h[o] : r_w[o];
            if (c > w_agg) begin
                w_agg = c;
            end
        end
    end

    assign w_ax = $signed({1'b0, r_agg}) * r_agg_x;

    always_ff @(posedge i_clk) begin
        r_agg   <= w_agg;
        r_agg_x <= r_tx[LANE_LAT-1];
        if (i_cmd.load) begin
            r_num <= '0;
            r_den <= '0;
        end else if (r_agg_v) begin
            r_num <= r_num + NUM_W'(w_ax);
            r_den <= r_den + DEN_W'(r_agg);
        end
    end

    assign w_mag = r_num[NUM_W-1] ? -r_num : r_num;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg <= r_num[NUM_W-1];
        end
    end

    fpd_div #(.MAG_W(MAG_W), .DEN_W(DEN_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_mag[MAG_W-1:0]),
        .i_divisor  (r_den),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        logic any_e;
        logic any_de;
        any_e  = 1'b0;
        any_de = 1'b0;
        for (int s = 0; s < NUM_SETS; s++) begin
            any_e  = any_e  || (r_mu_e[s]  != '0);
            any_de = any_de || (r_mu_de[s] != '0);
        end
        w_fired = any_e && any_de;
    end

    assign w_q8 = w_quo[DRIVE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_nrf <= !w_fired;
            if (w_fired && (r_den != '0)) begin
                r_drive <= r_neg ? -$signed(w_q8) : $signed(w_q8);
            end else begin
                r_drive <= '0;
            end
        end
    end

    always_comb begin
        w_busy = r_agg_v;
        for (int k = 0; k < LANE_LAT; k++) begin
            w_busy = w_busy || r_tv[k];
        end
    end

    assign o_sts.pipe_busy = w_busy;
    assign o_sts.div_done  = w_div_done;
    assign o_drive         = r_drive;
    assign o_no_rule_fired = r_nrf;
endmodule

FILE: tb/fuzzy_pd_controller_tb.sv
// ----------------------------------------------------------------------------
// fuzzy_pd_controller_tb: self-checking bench of the fuzzy PD controller
// Reference and position items are driven from a queue with random gaps. An
// in-bench predictor works out the drive and the no-rule flag of every
// accepted item. A monitor, with random stalls, checks each result against
// the oldest prediction.
// ----------------------------------------------------------------------------
module fuzzy_pd_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fpd_pkg::*;

    typedef struct {
        logic signed [IN_W-1:0] reference;
        logic signed [IN_W-1:0] position;
    } t_sample;

    typedef struct {
        logic signed [DRIVE_W-1:0] drive;
        logic                      no_rule;
    } t_drive;

    localparam int SPAN       = OUTPUT_SPAN_DEF;
    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fpd_in_if  in_ch();
    fpd_out_if out_ch();

    fuzzy_pd_controller dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_sample pending_samples[$];
    t_drive  expected_drives[$];
    logic signed [IN_W-1:0] pred_last_error;
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  stimulus_done = 0;
    bit  in_taken = 0;
    int  in_gap = 0;
    int  out_stall = 0;

    // Most gaps are short; now and then one is long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Parabolic membership height of set s at x; zero on and beyond the bounds.
    function automatic int set_height(int s, int x);
        int a, b, m;
        a = SET_LO[s];
        b = SET_HI[s];
        if (!(a < x && x < b)) return 0;
        m = (a + b) / 2;
        return (100 * (x - a) * (b - x)) / ((m - a) * (b - m));
    endfunction

    // Advances the stored error and returns the centroid drive of one sample.
    function automatic t_drive predict_drive(t_sample s);
        t_drive r;
        logic signed [IN_W-1:0] err, derr;
        int mu_e[NUM_SETS], mu_d[NUM_SETS];
        int area[SPAN];
        longint num, den;
        int w, o, h;
        bit fired;
        err = s.reference - s.position;
        derr = err - pred_last_error;
        pred_last_error = err;
        fired = 0;
        num = 0;
        den = 0;
        for (int i = 0; i < NUM_SETS; i++) begin
            mu_e[i] = set_height(i, err);
            mu_d[i] = set_height(i, derr);
        end
        for (int i = 0; i < SPAN; i++) area[i] = 0;
        for (int i = 0; i < NUM_SETS; i++) begin
            for (int j = 0; j < NUM_SETS; j++) begin
                if (mu_e[i] != 0 && mu_d[j] != 0) begin
                    fired = 1;
                    w = (mu_e[i] < mu_d[j]) ? mu_e[i] : mu_d[j];
                    o = RULE_TAB[i][j];
                    for (int x = SET_LO[o]; x <= SET_HI[o]; x++) begin
                        if (x + SPAN / 2 >= 0 && x + SPAN / 2 < SPAN) begin
                            h = set_height(o, x);
                            if (h > w) h = w;
                            if (area[x + SPAN / 2] < h) area[x + SPAN / 2] = h;
                        end
                    end
                end
            end
        end
        for (int i = 0; i < SPAN; i++) begin
            num += longint'(area[i]) * (i - SPAN / 2);
            den += area[i];
        end
        r.drive = (fired && den > 0) ? DRIVE_W'(num / den) : '0;
        r.no_rule = !fired;
        return r;
    endfunction

    // Driver: presents queued samples, inserting random gaps between them.
    always @(negedge i_clk) begin
        if (in_taken) begin
            // The item taken at the last rising edge is dropped; a gap may follow.
            void'(pending_samples.pop_front());
            in_taken <= 1'b0;
            in_gap <= pick_gap();
            in_ch.valid <= 1'b0;
        end else if (!i_rst_n || in_ch.valid) begin
            // Still held, or reset not yet released.
        end else if (in_gap > 0) begin
            in_gap <= in_gap - 1;
        end else if (pending_samples.size() > 0) begin
            in_ch.valid <= 1'b1;
            in_ch.reference <= pending_samples[0].reference;
            in_ch.position <= pending_samples[0].position;
        end
    end

    // Monitor: predicts on acceptance at the rising edge and checks results.
    always @(posedge i_clk) begin
        t_drive exp_d;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                expected_drives.push_back(predict_drive('{in_ch.reference, in_ch.position}));
                in_taken <= 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_drives.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: drive %0d no_rule %0b",
                                 out_ch.drive, out_ch.no_rule_fired);
                end else begin
                    exp_d = expected_drives.pop_front();
                    if (out_ch.drive !== exp_d.drive
                            || out_ch.no_rule_fired !== exp_d.no_rule) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: drive %0d/%0d no_rule %0b/%0b (exp/act)",
                                     exp_d.drive, out_ch.drive, exp_d.no_rule,
                                     out_ch.no_rule_fired);
                    end
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver stalls change at the falling edge, like the driver.
    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) out_stall <= pick_gap();
        end
    end

    // Watchdog: a long stretch with nothing accepted ends the run.
    always @(posedge i_clk) begin
        if (idle_cycles > STALL_LIMIT) begin
            $display("** fuzzy_pd_controller: FAILED **");
            $finish;
        end
    end

    task automatic add_sample(int r, int p);
        pending_samples.push_back('{IN_W'(r), IN_W'(p)});
    endtask

    initial begin
        int e;
        in_ch.valid = 1'b0;
        in_ch.reference = '0;
        in_ch.position = '0;
        out_ch.ready = 1'b0;
        pred_last_error = '0;

        // Directed: zero error, field extremes, wrap-around, set edges
        // and peaks, and a large jump in error change.
        add_sample(0, 0);
        add_sample(32767, -32768);
        add_sample(-32768, 32767);
        add_sample(-32768, -32768);
        add_sample(32767, 32767);
        add_sample(-1, 0);
        add_sample(0, 1);
        add_sample(10, 0);
        add_sample(10, 0);
        add_sample(-100, 0);
        add_sample(-55, 0);
        add_sample(100, 0);
        add_sample(55, 0);
        add_sample(-30, 0);
        add_sample(30, 0);
        add_sample(20, 0);
        add_sample(-20, 0);
        add_sample(50, 0);
        add_sample(-50, 0);
        add_sample(0, 0);
        add_sample(1000, 0);
        add_sample(5, 3);
        add_sample(-5, -3);
        add_sample(16'sh5555, 16'shAAAA);

        // Random: mostly small errors that move slowly so rules fire, with
        // some full-range noise to toggle every bit.
        e = 0;
        for (int n = 0; n < 850; n++) begin
            int p, k;
            p = $signed(16'($urandom()));
            k = $urandom_range(0, 9);
            if (k < 6) begin
                e += $urandom_range(0, 40) - 20;
                if (e > 110) e = 110;
                if (e < -110) e = -110;
            end else if (k < 8) begin
                e = $urandom_range(0, 220) - 110;
            end else begin
                e = $signed(16'($urandom()));
            end
            add_sample(p + e, p);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_samples.size() == 0 && !in_ch.valid);
        stimulus_done = 1;
        wait (expected_drives.size() == 0);
        repeat (300) @(posedge i_clk);

        if (mismatches == 0 && expected_drives.size() == 0) begin
            $display("** fuzzy_pd_controller: PASSED **");
        end else begin
            $display("** fuzzy_pd_controller: FAILED **");
        end
        $finish;
    end

endmodule

FILE: fuzzy_pd_controller.f
rtl/fpd_pkg.sv
rtl/fpd_if.sv
rtl/fpd_lane.sv
rtl/fpd_div.sv
rtl/fpd_ctrl.sv
rtl/fpd_dp.sv
rtl/fuzzy_pd_controller.sv
tb/fuzzy_pd_controller_tb.sv
